// File: hdl/bps_pkg.sv
// package for the block padding stripper: codes, constants and shared types
`default_nettype none

package bps_pkg;

    // default largest cipher block in bytes
    localparam int DEF_MAX_BLOCK = 32;

    // depth of the command queue between front and back
    localparam int Q_DEPTH = 2;

    // field widths
    localparam int BYTE_W   = 8;
    localparam int SCHEME_W = 3;
    localparam int BS_W     = 6;
    localparam int PAD_W    = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCHEME     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_MODE = 2'd2;

    // configuration reset values
    localparam logic [SCHEME_W-1:0] SCHEME_RESET = 3'd0;
    localparam logic [BS_W-1:0]     BS_RESET     = 6'd16;
    localparam logic                MODE_RESET   = 1'b1;

    // padding scheme codes
    localparam logic [SCHEME_W-1:0] SCH_NONE     = 3'd0;
    localparam logic [SCHEME_W-1:0] SCH_ANSI     = 3'd1;
    localparam logic [SCHEME_W-1:0] SCH_PKCS7    = 3'd2;
    localparam logic [SCHEME_W-1:0] SCH_ISO10126 = 3'd3;
    localparam logic [SCHEME_W-1:0] SCH_ISO7816  = 3'd4;
    localparam logic [SCHEME_W-1:0] SCH_ZERO     = 3'd5;
    localparam logic [SCHEME_W-1:0] SCH_SPACE    = 3'd6;

    // byte values used by the schemes
    localparam logic [BYTE_W-1:0] BYTE_MARK  = 8'h80;
    localparam logic [BYTE_W-1:0] BYTE_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] BYTE_ZERO  = 8'h00;

    // one classified word handed from front to back
    typedef struct packed {
        logic [BYTE_W-1:0]   data;
        logic                pop;
        logic                last;
        logic                strip;
        logic [SCHEME_W-1:0] scheme;
        logic [BS_W-1:0]     bs;
    } t_cmd;

    // back end sequencer states
    typedef enum logic [1:0] {
        ST_RUN,
        ST_SCAN,
        ST_FLUSH
    } t_back_state;

endpackage

`default_nettype wire

// File: hdl/bps_front.sv
// front end: configuration registers, length tracking and word classification
`default_nettype none

module bps_front
    import bps_pkg::*;
#(
    parameter int MAX_BLOCK = DEF_MAX_BLOCK
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [BYTE_W-1:0]     i_in_byte,
    input  wire logic                  i_in_last,
    output logic                       o_push,
    output t_cmd                       o_cmd,
    input  wire logic                  i_q_ready
);

    localparam int CW = $clog2(MAX_BLOCK + 3);
    localparam int RW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;

    logic [SCHEME_W-1:0] r_scheme;
    logic [BS_W-1:0]     r_bs;
    logic                r_mode;
    logic [RW-1:0]       r_rem;
    logic [RW-1:0]       n_rem;
    logic [CW-1:0]       r_cnt;
    logic [CW-1:0]       n_cnt;
    logic                bs_ok;
    logic [CW-1:0]       depth;
    logic [BS_W:0]       rem_inc;
    logic                pop;
    logic                accept;

    // block size check, hold depth and running length remainder
    always_comb begin
        bs_ok   = (r_bs != '0) && (r_bs <= BS_W'(MAX_BLOCK));
        depth   = bs_ok ? (CW'(r_bs) + CW'(1)) : CW'(1);
        rem_inc = (BS_W+1)'(r_rem) + (BS_W+1)'(1);
        if (bs_ok && (rem_inc < {1'b0, r_bs})) begin
            n_rem = RW'(rem_inc);
        end else begin
            n_rem = '0;
        end
        pop    = (r_cnt >= depth);
        accept = i_in_valid && i_q_ready;
    end

    // classified word for the queue
    always_comb begin
        o_in_ready   = i_q_ready;
        o_push       = accept;
        o_cmd.data   = i_in_byte;
        o_cmd.pop    = pop;
        o_cmd.last   = i_in_last;
        o_cmd.strip  = r_mode && bs_ok && (n_rem == '0);
        o_cmd.scheme = r_scheme;
        o_cmd.bs     = r_bs;
    end

    // held count as seen by the back end
    always_comb begin
        n_cnt = r_cnt;
        if (accept) begin
            if (i_in_last) begin
                n_cnt = '0;
            end else if (!pop) begin
                n_cnt = r_cnt + CW'(1);
            end
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scheme <= SCHEME_RESET;
            r_bs     <= BS_RESET;
            r_mode   <= MODE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SCHEME:     r_scheme <= i_cfg_wdata[SCHEME_W-1:0];
                REG_BLOCK_SIZE: r_bs     <= i_cfg_wdata[BS_W-1:0];
                REG_BLOCK_MODE: r_mode   <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // message tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (accept) begin
                r_rem <= i_in_last ? '0 : n_rem;
            end
        end
    end

endmodule

`default_nettype wire

// File: hdl/bps_queue.sv
// short word queue between the front end and the back end
`default_nettype none

module bps_queue
    import bps_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_cmd      i_wdata,
    output logic      o_ready,
    output logic      o_valid,
    output t_cmd      o_rdata,
    input  wire logic i_pop
);

    localparam int QW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QC = $clog2(Q_DEPTH + 1);

    t_cmd          r_buf [Q_DEPTH];
    logic [QW-1:0] r_wp;
    logic [QW-1:0] r_rp;
    logic [QC-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    // handshake on both sides
    always_comb begin
        o_ready = (r_cnt != QC'(Q_DEPTH));
        o_valid = (r_cnt != '0);
        o_rdata = r_buf[r_rp];
        do_push = i_push && o_ready;
        do_pop  = i_pop && o_valid;
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_buf[r_wp] <= i_wdata;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == QW'(Q_DEPTH - 1)) ? '0 : r_wp + QW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == QW'(Q_DEPTH - 1)) ? '0 : r_rp + QW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + QC'(1);
                2'b01:   r_cnt <= r_cnt - QC'(1);
                default: ;
            endcase
        end
    end

`ifndef SYNTH
    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QC'(Q_DEPTH))
        else $error("queue fill count beyond depth");
`endif

endmodule

`default_nettype wire

// File: hdl/bps_back.sv
// back end: hold buffer memory, pad scan and output register
`default_nettype none

module bps_back
    import bps_pkg::*;
#(
    parameter int MAX_BLOCK = DEF_MAX_BLOCK
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cmd_valid,
    input  t_cmd               i_cmd,
    output logic               o_cmd_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output logic [BYTE_W-1:0]  o_out_byte,
    output logic               o_byte_valid,
    output logic               o_out_last,
    output logic [PAD_W-1:0]   o_pad_length
);

    localparam int DEPTH = MAX_BLOCK + 1;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_BLOCK + 3);

    t_back_state         r_state;
    t_back_state         n_state;
    logic [BYTE_W-1:0]   r_mem [DEPTH];
    logic [PW-1:0]       r_head;
    logic [PW-1:0]       r_tail;
    logic [PW-1:0]       r_sptr;
    logic [CW-1:0]       r_held;
    logic [CW-1:0]       r_n;
    logic [CW-1:0]       r_k;
    logic [CW-1:0]       r_ek;
    logic [CW-1:0]       r_left;
    logic                r_ev;
    logic [PAD_W-1:0]    r_pad;
    logic [BYTE_W-1:0]   r_plen;
    logic [BYTE_W-1:0]   r_scan_data;
    logic [SCHEME_W-1:0] r_sch;
    logic [BS_W-1:0]     r_bs;
    logic                r_out_vld;
    logic [BYTE_W-1:0]   r_out_byte;
    logic                r_out_bv;
    logic                r_out_last;
    logic [PAD_W-1:0]    r_out_pad;

    logic                out_free;
    logic                take_ok;
    logic                cmd_take;
    logic                scan_go;
    logic                emit_byte;
    logic                emit_mark;
    logic                flush_end;
    logic [CW-1:0]       held_new;
    logic                sc_done;
    logic [BYTE_W-1:0]   sc_pad;
    logic [BYTE_W-1:0]   e8;
    logic [BYTE_W-1:0]   n8;
    logic [BYTE_W-1:0]   bs8;
    logic [BYTE_W-1:0]   d;
    logic [BYTE_W-1:0]   want;
    logic [BYTE_W-1:0]   run_char;

    // pad decision for one scanned byte, newest first
    always_comb begin
        e8       = BYTE_W'(r_ek);
        n8       = BYTE_W'(r_n);
        bs8      = BYTE_W'(r_bs);
        d        = r_scan_data;
        want     = (r_sch == SCH_ANSI) ? BYTE_ZERO : r_plen;
        run_char = (r_sch == SCH_ZERO) ? BYTE_ZERO : BYTE_SPACE;
        sc_done  = 1'b0;
        sc_pad   = '0;
        case (r_sch) inside
            SCH_ANSI, SCH_PKCS7: begin
                if (e8 == '0) begin
                    if ((d == '0) || (d > bs8) || (d > n8)) begin
                        sc_done = 1'b1;
                    end else if (d == BYTE_W'(1)) begin
                        sc_done = 1'b1;
                        sc_pad  = d;
                    end
                end else if (d != want) begin
                    sc_done = 1'b1;
                end else if (e8 == r_plen - BYTE_W'(1)) begin
                    sc_done = 1'b1;
                    sc_pad  = r_plen;
                end
            end
            SCH_ISO10126: begin
                sc_done = 1'b1;
                if ((d != '0) && (d <= bs8) && (d <= n8)) begin
                    sc_pad = d;
                end
            end
            SCH_ISO7816: begin
                if (!((e8 + BYTE_W'(1) < n8) && (d == BYTE_ZERO) && (e8 < bs8))) begin
                    sc_done = 1'b1;
                    if ((d == BYTE_MARK) && (e8 < bs8)) begin
                        sc_pad = e8 + BYTE_W'(1);
                    end
                end
            end
            SCH_ZERO, SCH_SPACE: begin
                if (!((e8 < n8) && (d == run_char) && (e8 <= bs8))) begin
                    sc_done = 1'b1;
                    if (e8 <= bs8) begin
                        sc_pad = e8;
                    end
                end
            end
            default: begin
                sc_done = 1'b1;
            end
        endcase
    end

    // word intake and emission strobes
    always_comb begin
        out_free  = !r_out_vld || i_out_ready;
        take_ok   = (r_state == ST_RUN) && (!i_cmd.pop || out_free);
        cmd_take  = take_ok && i_cmd_valid;
        held_new  = i_cmd.pop ? r_held : r_held + CW'(1);
        scan_go   = i_cmd.strip && (i_cmd.scheme != SCH_NONE)
                    && (i_cmd.scheme <= SCH_SPACE);
        emit_byte = (cmd_take && i_cmd.pop)
                    || ((r_state == ST_FLUSH) && out_free && (r_left != '0));
        emit_mark = (r_state == ST_FLUSH) && out_free && (r_left == '0);
        flush_end = (r_state == ST_FLUSH) && out_free && (r_left <= CW'(1));
        o_cmd_ready  = take_ok;
        o_out_valid  = r_out_vld;
        o_out_byte   = r_out_bv ? r_out_byte : BYTE_ZERO;
        o_byte_valid = r_out_bv;
        o_out_last   = r_out_last;
        o_pad_length = r_out_pad;
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_RUN: begin
                if (cmd_take && i_cmd.last) begin
                    n_state = scan_go ? ST_SCAN : ST_FLUSH;
                end
            end
            ST_SCAN: begin
                if (r_ev && sc_done) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (flush_end) begin
                    n_state = ST_RUN;
                end
            end
            default: n_state = ST_RUN;
        endcase
    end

    // hold buffer: one write port, output read port, scan read port
    always_ff @(posedge i_clk) begin
        if (cmd_take) begin
            r_mem[r_head] <= i_cmd.data;
        end
        if (emit_byte) begin
            r_out_byte <= r_mem[r_tail];
        end
        if (r_state == ST_SCAN) begin
            r_scan_data <= r_mem[r_sptr];
        end
    end

    // scan and flush bookkeeping
    always_ff @(posedge i_clk) begin
        if (cmd_take && i_cmd.last) begin
            r_n    <= held_new;
            r_sch  <= i_cmd.scheme;
            r_bs   <= i_cmd.bs;
            r_k    <= '0;
            r_sptr <= r_head;
            if (!scan_go) begin
                r_pad  <= '0;
                r_left <= held_new;
            end
        end
        if (r_state == ST_SCAN) begin
            r_sptr <= (r_sptr == '0) ? PW'(DEPTH - 1) : r_sptr - PW'(1);
            r_k    <= r_k + CW'(1);
            r_ek   <= r_k;
            if (r_ev && (r_ek == '0)) begin
                r_plen <= r_scan_data;
            end
            if (r_ev && sc_done) begin
                r_pad  <= PAD_W'(sc_pad);
                r_left <= r_n - CW'(sc_pad);
            end
        end
        if ((r_state == ST_FLUSH) && emit_byte) begin
            r_left <= r_left - CW'(1);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
            r_head  <= '0;
            r_tail  <= '0;
            r_held  <= '0;
            r_ev    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cmd_take) begin
                r_head <= (r_head == PW'(DEPTH - 1)) ? '0 : r_head + PW'(1);
                r_held <= held_new;
                r_ev   <= 1'b0;
            end
            if (emit_byte) begin
                r_tail <= (r_tail == PW'(DEPTH - 1)) ? '0 : r_tail + PW'(1);
            end
            if (r_state == ST_SCAN) begin
                r_ev <= 1'b1;
            end
            // drop pad bytes left in the buffer at message end
            if (flush_end) begin
                r_tail <= r_head;
                r_held <= '0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (emit_byte || emit_mark) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_byte || emit_mark) begin
            r_out_bv   <= emit_byte;
            r_out_last <= flush_end;
            r_out_pad  <= flush_end ? r_pad : '0;
        end
    end

`ifndef SYNTH
    a_marker_all_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH && r_left == '0) |-> (r_pad != '0 && CW'(r_pad) == r_n))
        else $error("end marker without whole message stripped");
    a_marker_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out_bv) |-> r_out_last)
        else $error("end marker not flagged last");
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= CW'(DEPTH))
        else $error("hold count beyond buffer depth");
    a_pop_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd_take && i_cmd.pop) |-> (r_held != '0))
        else $error("pass-through from an empty hold buffer");
`endif

endmodule

`default_nettype wire

// File: hdl/block_padding_stripper_top.sv
// top level of the block padding stripper
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one decrypted byte per word,
//   i_in_last on the final byte of a message. Output channel (o_out_valid /
//   i_out_ready) carries kept bytes; the final word of a message has o_out_last
//   and o_pad_length set, or is a bare end marker (o_byte_valid low) when the
//   whole message was padding. Configuration is written through i_cfg_we /
//   i_cfg_idx / i_cfg_wdata while the block is idle.
// Throughput: one byte per cycle in the middle of a message while the receiver
//   keeps up. The newest block_size+1 bytes are held back, so a byte leaves
//   through the queue and the output register once a newer byte pushes it out.
// Message end: the pad scan reads the hold buffer one byte per cycle over its
//   second read port, then the kept bytes leave one per cycle from the first
//   read port while the receiver keeps up; a two-word queue keeps accepting
//   input meanwhile.
// Reset (synchronous, active low) empties the queue and hold buffer and loads
//   scheme none, block size 16 and block mode on.
// A stalled receiver holds the output register; the back end then stops, the
//   queue fills and o_in_ready drops.
`default_nettype none

module block_padding_stripper_top
    import bps_pkg::*;
#(
    parameter int MAX_BLOCK = DEF_MAX_BLOCK
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [BYTE_W-1:0]     i_in_byte,
    input  wire logic                  i_in_last,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [BYTE_W-1:0]          o_out_byte,
    output logic                       o_byte_valid,
    output logic                       o_out_last,
    output logic [PAD_W-1:0]           o_pad_length
);

    logic push;
    t_cmd push_cmd;
    logic q_ready;
    logic q_valid;
    t_cmd q_cmd;
    logic q_pop;

    // classification and configuration
    bps_front #(
        .MAX_BLOCK (MAX_BLOCK)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_byte   (i_in_byte),
        .i_in_last   (i_in_last),
        .o_push      (push),
        .o_cmd       (push_cmd),
        .i_q_ready   (q_ready)
    );

    // decoupling queue
    bps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (push_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_rdata (q_cmd),
        .i_pop   (q_pop)
    );

    // hold buffer, pad scan and output
    bps_back #(
        .MAX_BLOCK (MAX_BLOCK)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (q_valid),
        .i_cmd        (q_cmd),
        .o_cmd_ready  (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_out_last   (o_out_last),
        .o_pad_length (o_pad_length)
    );

endmodule

`default_nettype wire

// File: test/tb.sv
// testbench for the block padding stripper: directed table, random messages, predictor check
`timescale 1ns / 1ps

module tb;
    import bps_pkg::*;

    localparam int MAX_BLK     = DEF_MAX_BLOCK;
    localparam int SETTLE_CYC  = 2 * MAX_BLK + 16;
    localparam int STALL_LIMIT = 2000;
    localparam int RAND_ITEMS  = 130;
    localparam int N_PHASES    = 12;
    localparam int N_ROWS      = 21;
    localparam int MAX_REPORTS = 20;

    // scheme code the block treats as none
    localparam logic [SCHEME_W-1:0] SCH_UNUSED = 3'd7;

    // one output word as the block should give it
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              dvalid;
        logic              last;
        logic [PAD_W-1:0]  pad;
    } t_word;

    // one directed input byte with the settings it runs under
    typedef struct packed {
        logic [SCHEME_W-1:0] sch;
        logic [BS_W-1:0]     bs;
        logic                mode;
        logic [BYTE_W-1:0]   b;
        logic                fin;
        logic                chk;
        logic [PAD_W-1:0]    pad;
    } t_row;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    logic [BYTE_W-1:0]     i_in_byte   = '0;
    logic                  i_in_last   = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [BYTE_W-1:0]     o_out_byte;
    logic                  o_byte_valid;
    logic                  o_out_last;
    logic [PAD_W-1:0]      o_pad_length;

    // predictor copy of the settings and the hold buffer
    logic [SCHEME_W-1:0] cur_scheme = SCHEME_RESET;
    logic [BS_W-1:0]     cur_bs     = BS_RESET;
    logic                cur_mode   = MODE_RESET;
    logic [BYTE_W-1:0]   held_q [0:MAX_BLK];
    int unsigned         held_n  = 0;
    int unsigned         len_mod = 0;

    t_word             due_words [$];
    t_word             want;
    logic [BYTE_W-1:0] msg_q [$];

    logic calm = 1'b0;
    int   fail_count = 0;
    int   idle_cycles = 0;
    int   bytes_in = 0;
    int   msgs_in = 0;
    int   words_out = 0;
    int   markers_out = 0;
    int   cfg_writes = 0;

    // directed messages: reset settings, each scheme, extremes, bad block sizes
    t_row directed_rows [0:N_ROWS-1] = '{
        '{SCH_NONE,     6'd16, 1'b1, 8'hFF, 1'b1, 1'b1, 6'd0},
        '{SCH_PKCS7,    6'd2,  1'b1, 8'h00, 1'b0, 1'b0, 6'd0},
        '{SCH_PKCS7,    6'd2,  1'b1, 8'h01, 1'b1, 1'b1, 6'd1},
        '{SCH_PKCS7,    6'd2,  1'b1, 8'h02, 1'b0, 1'b0, 6'd0},
        '{SCH_PKCS7,    6'd2,  1'b1, 8'h02, 1'b1, 1'b1, 6'd2},
        '{SCH_ANSI,     6'd4,  1'b1, 8'hFF, 1'b0, 1'b0, 6'd0},
        '{SCH_ANSI,     6'd4,  1'b1, 8'h00, 1'b0, 1'b0, 6'd0},
        '{SCH_ANSI,     6'd4,  1'b1, 8'h00, 1'b0, 1'b0, 6'd0},
        '{SCH_ANSI,     6'd4,  1'b1, 8'h03, 1'b1, 1'b1, 6'd3},
        '{SCH_ISO10126, 6'd2,  1'b1, 8'hAB, 1'b0, 1'b0, 6'd0},
        '{SCH_ISO10126, 6'd2,  1'b1, 8'h00, 1'b1, 1'b1, 6'd0},
        '{SCH_ISO7816,  6'd2,  1'b1, 8'h80, 1'b0, 1'b0, 6'd0},
        '{SCH_ISO7816,  6'd2,  1'b1, 8'h00, 1'b1, 1'b0, 6'd0},
        '{SCH_ZERO,     6'd1,  1'b1, 8'h00, 1'b0, 1'b0, 6'd0},
        '{SCH_ZERO,     6'd1,  1'b1, 8'h00, 1'b1, 1'b0, 6'd0},
        '{SCH_SPACE,    6'd2,  1'b1, 8'h41, 1'b0, 1'b0, 6'd0},
        '{SCH_SPACE,    6'd2,  1'b1, 8'h20, 1'b1, 1'b0, 6'd0},
        '{SCH_PKCS7,    6'd1,  1'b0, 8'h01, 1'b1, 1'b1, 6'd0},
        '{SCH_UNUSED,   6'd1,  1'b1, 8'h01, 1'b1, 1'b1, 6'd0},
        '{SCH_PKCS7,    6'd0,  1'b1, 8'h01, 1'b1, 1'b1, 6'd0},
        '{SCH_PKCS7,    6'd63, 1'b1, 8'h01, 1'b1, 1'b1, 6'd0}
    };

    // settings walked by the random part
    logic [SCHEME_W-1:0] phase_sch [0:N_PHASES-1] = '{
        SCH_PKCS7, SCH_ANSI, SCH_ISO7816, SCH_ZERO, SCH_SPACE, SCH_ISO10126,
        SCH_PKCS7, SCH_ANSI, SCH_ZERO, SCH_ISO7816, SCH_SPACE, SCH_PKCS7
    };
    logic [BS_W-1:0] phase_bs [0:N_PHASES-1] = '{
        6'd1, 6'd32, 6'd4, 6'd8, 6'd3, 6'd16, 6'd7, 6'd2, 6'd1, 6'd32, 6'd5, 6'd16
    };
    logic phase_mode [0:N_PHASES-1] = '{
        1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1
    };

    block_padding_stripper_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_byte    (i_in_byte),
        .i_in_last    (i_in_last),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_out_last   (o_out_last),
        .o_pad_length (o_pad_length)
    );

    // clock, 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        if (fail_count < MAX_REPORTS)
            $display("mismatch at word %0d: %s is 0x%0h, should be 0x%0h",
                     words_out, what, got, exp_val);
        fail_count++;
    endtask

    function automatic void queue_word(input logic [BYTE_W-1:0] data, input logic dv,
                                       input logic last, input int unsigned pad);
        t_word w;
        w.data   = data;
        w.dvalid = dv;
        w.last   = last;
        w.pad    = PAD_W'(pad);
        due_words.push_back(w);
    endfunction

    // pad length found at the message end under the current scheme
    function automatic int unsigned scan_pad();
        int unsigned       n, bs, pad, cnt, i, k;
        logic [BYTE_W-1:0] tail, fill, pat;
        n    = held_n;
        bs   = cur_bs;
        tail = held_q[n - 1];
        pad  = 0;
        cnt  = 0;
        case (cur_scheme)
            SCH_ANSI, SCH_PKCS7: begin
                if (tail >= 1 && tail <= bs && tail <= n) begin
                    pad = tail;
                    pat = (cur_scheme == SCH_ANSI) ? BYTE_ZERO : tail;
                    for (k = 1; k < tail; k++)
                        if (held_q[n - 1 - k] != pat)
                            pad = 0;
                end
            end
            SCH_ISO10126: begin
                pad = tail;
            end
            SCH_ISO7816: begin
                // zeros back from the end, never past the oldest held byte
                i = n - 1;
                while (i > 0 && held_q[i] == BYTE_ZERO && cnt < bs) begin
                    cnt++;
                    i--;
                end
                pad = (held_q[i] == BYTE_MARK) ? cnt + 1 : 0;
            end
            SCH_ZERO, SCH_SPACE: begin
                fill = (cur_scheme == SCH_ZERO) ? BYTE_ZERO : BYTE_SPACE;
                while (cnt < n && cnt <= bs && held_q[n - 1 - cnt] == fill)
                    cnt++;
                pad = cnt;
            end
            default: ;
        endcase
        if (pad == 0 || pad > bs || pad > n)
            pad = 0;
        return pad;
    endfunction

    // expected words caused by one accepted byte
    function automatic void predict_strip(input logic [BYTE_W-1:0] b, input logic fin);
        int unsigned depth, rem, pad, keep, k;
        logic        bs_ok;
        bs_ok = (cur_bs >= 1 && cur_bs <= MAX_BLK);
        depth = bs_ok ? cur_bs + 1 : 1;
        rem   = len_mod + 1;
        if (!bs_ok || rem >= cur_bs)
            rem = 0;
        // oldest byte leaves once the hold is full
        if (held_n >= depth) begin
            queue_word(held_q[0], 1'b1, 1'b0, 0);
            for (k = 0; k + 1 < held_n; k++)
                held_q[k] = held_q[k + 1];
            held_n--;
        end
        held_q[held_n] = b;
        held_n++;
        if (!fin) begin
            len_mod = rem;
            return;
        end
        // message end: strip the pad, flush the rest
        pad = 0;
        if (cur_mode && bs_ok && rem == 0)
            pad = scan_pad();
        keep = held_n - pad;
        if (keep == 0)
            queue_word(BYTE_ZERO, 1'b0, 1'b1, pad);
        else
            for (k = 0; k < keep; k++)
                queue_word(held_q[k], 1'b1, k + 1 == keep, (k + 1 == keep) ? pad : 0);
        held_n  = 0;
        len_mod = 0;
    endfunction

    // one input word through the handshake, then predicted
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fin,
                             input logic chk, input logic [PAD_W-1:0] pad);
        int unsigned gap;
        t_word       w;
        if (!calm && $urandom_range(0, 99) < 13) begin
            gap = $urandom_range(1, 3);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        i_in_last  <= fin;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        bytes_in++;
        predict_strip(b, fin);
        if (fin) begin
            msgs_in++;
            // typed pad length of the closing word
            if (chk) begin
                w = due_words.pop_back();
                w.pad = pad;
                due_words.push_back(w);
            end
        end
    endtask

    // let every expected word drain and the block settle
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (due_words.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_SCHEME:     cur_scheme = val[SCHEME_W-1:0];
            REG_BLOCK_SIZE: cur_bs     = val[BS_W-1:0];
            REG_BLOCK_MODE: cur_mode   = val[0];
            default: ;
        endcase
        cfg_writes++;
        @(posedge i_clk);
    endtask

    task automatic apply_config(input logic [SCHEME_W-1:0] sch, input logic [BS_W-1:0] bs,
                                input logic mode);
        wait_drained();
        if (sch != cur_scheme)
            write_reg(REG_SCHEME, CFG_DATA_W'(sch));
        if (bs != cur_bs)
            write_reg(REG_BLOCK_SIZE, CFG_DATA_W'(bs));
        if (mode != cur_mode)
            write_reg(REG_BLOCK_MODE, CFG_DATA_W'(mode));
    endtask

    // bytes leaning toward pad values
    function automatic logic [BYTE_W-1:0] any_byte();
        case ($urandom_range(0, 5))
            0:       return BYTE_ZERO;
            1:       return BYTE_SPACE;
            2:       return BYTE_MARK;
            3:       return BYTE_W'($urandom_range(1, 4));
            default: return BYTE_W'($urandom);
        endcase
    endfunction

    // random message: mostly well padded, some noise, some with a broken pad
    task automatic build_message();
        int unsigned bs, nblk, total, padn, kind;
        msg_q.delete();
        bs    = (cur_bs >= 1 && cur_bs <= MAX_BLK) ? cur_bs : 4;
        nblk  = (bs > 4) ? 1 : $urandom_range(1, 3);
        kind  = $urandom_range(0, 99);
        if (kind < 20) begin
            total = $urandom_range(1, 2 * bs + 1);
            repeat (total) msg_q.push_back(any_byte());
        end else begin
            total = nblk * bs;
            padn  = $urandom_range(1, bs);
            repeat (total - padn) msg_q.push_back(any_byte());
            case (cur_scheme)
                SCH_ANSI: begin
                    repeat (padn - 1) msg_q.push_back(BYTE_ZERO);
                    msg_q.push_back(BYTE_W'(padn));
                end
                SCH_PKCS7: begin
                    repeat (padn) msg_q.push_back(BYTE_W'(padn));
                end
                SCH_ISO10126: begin
                    repeat (padn - 1) msg_q.push_back(BYTE_W'($urandom));
                    msg_q.push_back(BYTE_W'(padn));
                end
                SCH_ISO7816: begin
                    msg_q.push_back(BYTE_MARK);
                    repeat (padn - 1) msg_q.push_back(BYTE_ZERO);
                end
                SCH_ZERO: begin
                    repeat (padn) msg_q.push_back(BYTE_ZERO);
                end
                SCH_SPACE: begin
                    repeat (padn) msg_q.push_back(BYTE_SPACE);
                end
                default: begin
                    repeat (padn) msg_q.push_back(any_byte());
                end
            endcase
            if (kind < 32)
                msg_q[$urandom_range(total - padn, total - 1)] = BYTE_W'($urandom);
        end
    endtask

    // receiver stalls at random, none in the calm stretch
    always @(posedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(0, 99) >= 13);
    end

    // output words against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (due_words.size() == 0) begin
                report_mismatch("unexpected word, byte", o_out_byte, 0);
            end else begin
                want = due_words.pop_front();
                if (o_out_byte !== want.data)
                    report_mismatch("out_byte", o_out_byte, want.data);
                if (o_byte_valid !== want.dvalid)
                    report_mismatch("byte_valid", o_byte_valid, want.dvalid);
                if (o_out_last !== want.last)
                    report_mismatch("out_last", o_out_last, want.last);
                if (o_pad_length !== want.pad)
                    report_mismatch("pad_length", o_pad_length, want.pad);
            end
            if (!o_byte_valid)
                markers_out++;
            words_out++;
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("no word moved for %0d cycles, %0d still expected",
                     STALL_LIMIT, due_words.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // stimulus
    initial begin
        t_row        row;
        logic        at_start;
        int unsigned phase, n_msgs, rand_bytes, k;
        at_start   = 1'b1;
        phase      = 0;
        rand_bytes = 0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (k = 0; k < N_ROWS; k++) begin
            row = directed_rows[k];
            if (at_start && (row.sch != cur_scheme || row.bs != cur_bs || row.mode != cur_mode))
                apply_config(row.sch, row.bs, row.mode);
            send_byte(row.b, row.fin, row.chk, row.pad);
            at_start = row.fin;
        end

        // block size shrinks while bytes are held
        apply_config(SCH_PKCS7, 6'd32, 1'b1);
        send_byte(8'h10, 1'b0, 1'b0, '0);
        send_byte(8'h20, 1'b0, 1'b0, '0);
        send_byte(8'h30, 1'b0, 1'b0, '0);
        wait_drained();
        write_reg(REG_BLOCK_SIZE, CFG_DATA_W'(1));
        send_byte(8'h44, 1'b0, 1'b0, '0);
        send_byte(8'h01, 1'b1, 1'b0, '0);

        // random messages over a walk of settings
        while (rand_bytes < RAND_ITEMS) begin
            apply_config(phase_sch[phase % N_PHASES], phase_bs[phase % N_PHASES],
                         phase_mode[phase % N_PHASES]);
            calm   = (phase == 2 || phase == 3);
            n_msgs = (cur_bs > 8) ? 1 : 3;
            repeat (n_msgs) begin
                build_message();
                for (k = 0; k < msg_q.size(); k++)
                    send_byte(msg_q[k], k + 1 == msg_q.size(), 1'b0, '0);
                rand_bytes += msg_q.size();
            end
            phase++;
        end
        calm = 1'b0;

        wait_drained();
        $display("sent %0d bytes in %0d messages over %0d register writes", bytes_in, msgs_in,
                 cfg_writes);
        $display("checked %0d words, %0d of them bare end markers", words_out, markers_out);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
